[rtl/core/afd_pkg.sv]
package afd_pkg;

    // Default widths of the sample and length fields.
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_LENGTH_BITS = 24;

    // Fixed field widths.
    localparam int SKIP_BITS  = 16;
    localparam int VOL_BITS   = 16;
    localparam int RATIO_BITS = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Ratio divider runs one quotient bit per cycle.
    localparam int DIV_STEPS = RATIO_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Gain is Q0.16 (unity needs one more bit), volume is Q4.12.
    localparam int GAIN_W      = RATIO_BITS + 1;
    localparam int SCALE_SHIFT = RATIO_BITS + 12;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_DISCARD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_END     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_LEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_GAIN  = 3'd5;

    // Register reset values.
    localparam logic [SKIP_BITS-1:0] SKIP_RESET   = 16'd2;
    localparam logic [VOL_BITS-1:0]  VOLUME_RESET = 16'd4096;

    // Stream envelope phase.
    typedef enum logic [2:0] {
        PH_LEAD,
        PH_FADE_IN,
        PH_BODY,
        PH_FADE_OUT,
        PH_DONE
    } t_phase;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_SQ,
        S_CUBE,
        S_GV,
        S_SCALE,
        S_OUT
    } t_state;

    // Operand selection for the shared multiplier.
    typedef enum logic [1:0] {
        MS_SQ,
        MS_CUBE,
        MS_GV,
        MS_SCALE
    } t_mul_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     eval;
        logic     div_step;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic keep;
        logic kept_body;
        logic work_fade_in;
        logic out_free;
    } t_sts;

endpackage

[rtl/core/afd_ctrl.sv]
module afd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  afd_pkg::t_sts i_sts,
    output afd_pkg::t_cmd o_cmd
);

    afd_pkg::t_state r_state, n_state;
    logic [afd_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic div_last;

    assign div_last = (r_cnt == afd_pkg::CNT_W'(afd_pkg::DIV_STEPS - 1));

    // State and step counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= afd_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            afd_pkg::S_IDLE: begin
                if (i_s_valid) n_state = afd_pkg::S_EVAL;
            end
            afd_pkg::S_EVAL: begin
                if (!i_sts.keep) n_state = afd_pkg::S_IDLE;
                else if (i_sts.kept_body) n_state = afd_pkg::S_GV;
                else n_state = afd_pkg::S_DIV;
            end
            afd_pkg::S_DIV: begin
                if (div_last) begin
                    n_state = i_sts.work_fade_in ? afd_pkg::S_SQ : afd_pkg::S_GV;
                end
            end
            afd_pkg::S_SQ:    n_state = afd_pkg::S_CUBE;
            afd_pkg::S_CUBE:  n_state = afd_pkg::S_GV;
            afd_pkg::S_GV:    n_state = afd_pkg::S_SCALE;
            afd_pkg::S_SCALE: n_state = afd_pkg::S_OUT;
            afd_pkg::S_OUT: begin
                if (i_sts.out_free) n_state = afd_pkg::S_IDLE;
            end
            default: n_state = afd_pkg::S_IDLE;
        endcase
    end

    // Outputs: commands, input ready and the divider step counter.
    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = afd_pkg::MS_SQ;
        o_s_ready     = 1'b0;
        n_cnt         = r_cnt;
        unique case (r_state)
            afd_pkg::S_IDLE: begin
                o_s_ready     = 1'b1;
                o_cmd.capture = i_s_valid;
            end
            afd_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_cnt      = '0;
            end
            afd_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + afd_pkg::CNT_W'(1);
            end
            afd_pkg::S_SQ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = afd_pkg::MS_SQ;
            end
            afd_pkg::S_CUBE: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = afd_pkg::MS_CUBE;
            end
            afd_pkg::S_GV: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = afd_pkg::MS_GV;
            end
            afd_pkg::S_SCALE: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = afd_pkg::MS_SCALE;
            end
            afd_pkg::S_OUT: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_s_ready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/core/afd_dp.sv]
module afd_dp #(
    parameter int SAMPLE_BITS = afd_pkg::DEF_SAMPLE_BITS,
    parameter int LENGTH_BITS = afd_pkg::DEF_LENGTH_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [afd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [afd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    input  afd_pkg::t_cmd                   i_cmd,
    output afd_pkg::t_sts                   o_sts,
    input  logic                            i_m_ready,
    output logic                            o_m_valid,
    output logic [SAMPLE_BITS-1:0]          o_m_sample,
    output logic                            o_m_last
);

    localparam int S  = SAMPLE_BITS;
    localparam int L  = LENGTH_BITS;
    localparam int RB = afd_pkg::RATIO_BITS;
    localparam int MA = afd_pkg::GAIN_W + afd_pkg::VOL_BITS;
    localparam int MB = (S > RB) ? S : RB;
    localparam int PW = MA + MB;
    localparam int QW = PW - afd_pkg::SCALE_SHIFT;
    localparam logic [QW-1:0] QHALF = QW'(1) << (S - 1);
    localparam logic [QW-1:0] QMAXP = QHALF - QW'(1);
    localparam logic [afd_pkg::GAIN_W-1:0] UNITY = afd_pkg::GAIN_W'(1) << RB;

    // Configuration registers.
    logic [L-1:0]                  r_lead_discard;
    logic [afd_pkg::SKIP_BITS-1:0] r_skip_count;
    logic [L-1:0]                  r_fade_in_len;
    logic [L-1:0]                  r_body_end;
    logic [L-1:0]                  r_fade_out_len;
    logic [afd_pkg::VOL_BITS-1:0]  r_volume;

    // Stream state.
    afd_pkg::t_phase               r_phase;
    logic [L-1:0]                  r_lead_cnt;
    logic [afd_pkg::SKIP_BITS-1:0] r_skip_cnt;
    logic [L-1:0]                  r_pos;

    // Working registers of the item in flight.
    logic                 r_neg;
    logic [S-1:0]         r_mag;
    afd_pkg::t_phase      r_wph;
    logic                 r_flag;
    logic [L-1:0]         r_rem;
    logic [L-1:0]         r_div;
    logic [RB-1:0]        r_q;
    logic [PW-1:0]        r_prod;

    // Output register.
    logic                 r_m_valid;
    logic [S-1:0]         r_m_sample;
    logic                 r_m_last;

    // Decision signals for the captured item.
    logic                          is_done;
    logic                          lead_wait;
    logic                          skip_wait;
    logic                          fo_end;
    logic                          flag;
    afd_pkg::t_phase               e_ph;
    afd_pkg::t_phase               k_ph;
    logic [L-1:0]                  e_pos;
    logic [L-1:0]                  k_pos;
    logic [L-1:0]                  pos_inc;
    logic [afd_pkg::SKIP_BITS-1:0] e_skip;

    // Divider and multiplier signals.
    logic [L:0]                    rem_sh;
    logic                          rem_ge;
    logic [afd_pkg::GAIN_W-1:0]    gain;
    logic [MA-1:0]                 mul_a;
    logic [MB-1:0]                 mul_b;
    logic [QW-1:0]                 q_mag;
    logic [QW-1:0]                 q_sat;
    logic [S-1:0]                  sat_sample;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_discard <= '0;
            r_skip_count   <= afd_pkg::SKIP_RESET;
            r_fade_in_len  <= '0;
            r_body_end     <= '0;
            r_fade_out_len <= '0;
            r_volume       <= afd_pkg::VOLUME_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                afd_pkg::REG_LEAD_DISCARD: r_lead_discard <= i_cfg_data[L-1:0];
                afd_pkg::REG_SKIP_COUNT:
                    r_skip_count <= i_cfg_data[afd_pkg::SKIP_BITS-1:0];
                afd_pkg::REG_FADE_IN_LEN:  r_fade_in_len <= i_cfg_data[L-1:0];
                afd_pkg::REG_BODY_END:     r_body_end <= i_cfg_data[L-1:0];
                afd_pkg::REG_FADE_OUT_LEN: r_fade_out_len <= i_cfg_data[L-1:0];
                afd_pkg::REG_VOLUME_GAIN:
                    r_volume <= i_cfg_data[afd_pkg::VOL_BITS-1:0];
                default: r_volume <= r_volume;
            endcase
        end
    end

    // Phase decision for the captured item: lead, skip, then phase moves.
    always_comb begin
        is_done   = (r_phase == afd_pkg::PH_DONE);
        lead_wait = (r_phase == afd_pkg::PH_LEAD) && (r_lead_cnt < r_lead_discard);
        e_ph      = (r_phase == afd_pkg::PH_LEAD) ? afd_pkg::PH_FADE_IN : r_phase;
        e_pos     = (r_phase == afd_pkg::PH_LEAD) ? '0 : r_pos;
        e_skip    = (r_phase == afd_pkg::PH_LEAD) ? '0 : r_skip_cnt;
        skip_wait = (e_skip < r_skip_count);
        k_ph      = e_ph;
        k_pos     = e_pos;
        if ((k_ph == afd_pkg::PH_FADE_IN) && (e_pos >= r_fade_in_len)) begin
            k_ph = afd_pkg::PH_BODY;
        end
        if ((k_ph == afd_pkg::PH_BODY) && (e_pos >= r_body_end)) begin
            k_ph  = afd_pkg::PH_FADE_OUT;
            k_pos = '0;
        end
        fo_end  = (k_ph == afd_pkg::PH_FADE_OUT) && (k_pos >= r_fade_out_len);
        flag    = (k_ph == afd_pkg::PH_FADE_OUT) &&
                  (({1'b0, k_pos} + (L + 1)'(1)) == {1'b0, r_fade_out_len});
        pos_inc = (&k_pos) ? k_pos : (k_pos + L'(1));
    end

    assign o_sts.keep         = !is_done && !lead_wait && !skip_wait && !fo_end;
    assign o_sts.kept_body    = (k_ph == afd_pkg::PH_BODY);
    assign o_sts.work_fade_in = (r_wph == afd_pkg::PH_FADE_IN);
    assign o_sts.out_free     = !r_m_valid || i_m_ready;

    // Stream state update, once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= afd_pkg::PH_LEAD;
            r_lead_cnt <= '0;
            r_skip_cnt <= '0;
            r_pos      <= '0;
        end else if (i_cmd.eval && !is_done) begin
            if (lead_wait) begin
                r_lead_cnt <= r_lead_cnt + L'(1);
            end else if (skip_wait) begin
                r_phase    <= e_ph;
                r_pos      <= e_pos;
                r_skip_cnt <= e_skip + afd_pkg::SKIP_BITS'(1);
            end else begin
                r_skip_cnt <= '0;
                if (fo_end) begin
                    r_phase <= afd_pkg::PH_DONE;
                    r_pos   <= k_pos;
                end else begin
                    r_phase <= flag ? afd_pkg::PH_DONE : k_ph;
                    r_pos   <= pos_inc;
                end
            end
        end
    end

    // Sample capture as sign and magnitude.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_neg <= i_sample[S-1];
            r_mag <= i_sample[S-1] ? (~i_sample + S'(1)) : i_sample;
        end
    end

    // Restoring divider: one ratio bit per step, remainder stays below the divisor.
    assign rem_sh = {r_rem, 1'b0};
    assign rem_ge = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_wph  <= k_ph;
            r_flag <= flag;
            r_rem  <= k_pos;
            r_div  <= (k_ph == afd_pkg::PH_FADE_IN) ? r_fade_in_len : r_fade_out_len;
            r_q    <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? L'(rem_sh - {1'b0, r_div}) : rem_sh[L-1:0];
            r_q   <= {r_q[RB-2:0], rem_ge};
        end
    end

    // Envelope gain in Q0.16; the cube sits in the product register after CUBE.
    always_comb begin
        case (r_wph)
            afd_pkg::PH_FADE_IN: gain = afd_pkg::GAIN_W'(r_prod[3*RB-1:2*RB]);
            afd_pkg::PH_BODY:    gain = UNITY;
            default:             gain = UNITY - afd_pkg::GAIN_W'(r_q);
        endcase
    end

    // Shared multiplier operand selection.
    always_comb begin
        case (i_cmd.mul_sel)
            afd_pkg::MS_SQ: begin
                mul_a = MA'(r_q);
                mul_b = MB'(r_q);
            end
            afd_pkg::MS_CUBE: begin
                mul_a = MA'(r_prod[2*RB-1:0]);
                mul_b = MB'(r_q);
            end
            afd_pkg::MS_GV: begin
                mul_a = MA'(gain);
                mul_b = MB'(r_volume);
            end
            default: begin
                mul_a = r_prod[MA-1:0];
                mul_b = MB'(r_mag);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // Truncate the magnitude, saturate, and restore the sign.
    always_comb begin
        q_mag = r_prod[PW-1:afd_pkg::SCALE_SHIFT];
        if (r_neg) begin
            q_sat      = (q_mag > QHALF) ? QHALF : q_mag;
            sat_sample = ~q_sat[S-1:0] + S'(1);
        end else begin
            q_sat      = (q_mag > QMAXP) ? QMAXP : q_mag;
            sat_sample = q_sat[S-1:0];
        end
    end

    // Output register: holds a result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_m_sample <= sat_sample;
            r_m_last   <= r_flag;
        end
    end

    assign o_m_valid  = r_m_valid;
    assign o_m_sample = r_m_sample;
    assign o_m_last   = r_m_last;

endmodule

[rtl/core/audio_fade_decimator_top.sv]
// Fade envelope and decimator for signed PCM samples. After reset the block drops
// lead_discard samples, then keeps one sample out of every skip_count+1 and passes
// each kept sample through a cubic fade-in, a unity-gain body and a linear
// fade-out, followed by a Q4.12 volume scale that truncates toward zero and
// saturates. The last fade-out sample carries tlast; all samples after it are
// dropped until the next reset. Dropped samples produce nothing. A kept sample
// passes through the serial ratio divider in the fade phases and through the
// single shared multiplier that does the square, cube, volume and sample
// products in turn, and waits in the output stage for as long as m_axis_tready
// is held low. A new sample is taken only once the last one is through.
// The configuration port is always ready and should be written while the block
// is idle.
module audio_fade_decimator_top #(
    parameter int SAMPLE_BITS = afd_pkg::DEF_SAMPLE_BITS,
    parameter int LENGTH_BITS = afd_pkg::DEF_LENGTH_BITS,
    localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [afd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [afd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [DATA_W-1:0]              s_axis_tdata,  // in_sample, zero padding above
    // Output stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [DATA_W-1:0]              m_axis_tdata,  // out_sample, zero padding above
    output logic                           m_axis_tlast
);

    afd_pkg::t_cmd            cmd;
    afd_pkg::t_sts            sts;
    logic [SAMPLE_BITS-1:0]   out_sample;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = DATA_W'(out_sample);

    // Sequencer.
    afd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // Counters, divider, multiplier and output stage.
    afd_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_sample  (out_sample),
        .o_m_last    (m_axis_tlast)
    );

endmodule

[rtl/core/afd_chk.sv]
module afd_chk #(
    parameter int DATA_W = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [DATA_W-1:0]              m_axis_tdata,
    input logic                           m_axis_tlast
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result payload changed while stalled");

    // Items are worked one at a time: no new item right after one is taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // A new result appears only from the final step, never while the input is open.
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while the block was idle");

    // The configuration channel never back-pressures.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind audio_fade_decimator_top afd_chk #(
    .DATA_W (DATA_W)
) u_afd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[sim/afd_envelope_checker.sv]
`timescale 1ns / 100ps

// Watches the configuration, input and output channels of the fade decimator.
// Each accepted input item runs through a private model of the envelope; kept
// samples queue an expected output item that the next accepted output must match.
module afd_envelope_checker
    import afd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // in_sample
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [15:0]           m_axis_tdata,  // out_sample
    input  logic                  m_axis_tlast,  // final_flag
    output int                    o_error_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [15:0] smp;
        logic        is_last;
    } t_faded_sample;

    // Register copies.
    logic [23:0] lead_len;
    logic [15:0] skip_len;
    logic [23:0] fade_in_len;
    logic [23:0] body_end;
    logic [23:0] fade_out_len;
    logic [15:0] volume;

    // Envelope state.
    t_phase      env_phase;
    logic [23:0] lead_cnt;
    logic [15:0] skip_cnt;
    logic [23:0] pos;

    t_faded_sample faded_q[$];
    int            mismatches = 0;

    assign o_error_count = mismatches;

    // floor(i * 65536 / n), zero for an empty span.
    function automatic logic [63:0] ratio_q16(input logic [23:0] i, input logic [23:0] n);
        if (n == '0) begin
            return 64'd0;
        end
        return {24'd0, i, 16'd0} / {40'd0, n};
    endfunction

    // Sign-magnitude scale by a Q0.16 gain and the Q4.12 volume, then saturate.
    function automatic logic [15:0] scale_sample(input logic [15:0] raw,
                                                 input logic [16:0] gain,
                                                 input logic [15:0] vol);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] neg_val;
        neg = raw[15];
        mag = neg ? (64'd65536 - {48'd0, raw}) : {48'd0, raw};
        q   = (mag * {47'd0, gain} * {48'd0, vol}) >> 28;
        if (!neg) begin
            return (q > 64'd32767) ? 16'h7FFF : q[15:0];
        end
        if (q > 64'd32768) begin
            q = 64'd32768;
        end
        neg_val = 64'd65536 - q;
        return neg_val[15:0];
    endfunction

    // Advances the envelope by one input sample and queues the output it causes.
    task automatic envelope_step(input logic [15:0] smp);
        logic [63:0]   r;
        logic [63:0]   cube;
        logic [16:0]   gain;
        logic          flag;
        t_faded_sample item;
        flag = 1'b0;
        if (env_phase == PH_DONE) begin
            return;
        end
        if (env_phase == PH_LEAD) begin
            if (lead_cnt < lead_len) begin
                lead_cnt = lead_cnt + 1'b1;
                return;
            end
            env_phase = PH_FADE_IN;
            pos       = '0;
            skip_cnt  = '0;
        end
        if (skip_cnt < skip_len) begin
            skip_cnt = skip_cnt + 1'b1;
            return;
        end
        skip_cnt = '0;

        // Phase moves, checked in order on every kept sample.
        if (env_phase == PH_FADE_IN && pos >= fade_in_len) begin
            env_phase = PH_BODY;
        end
        if (env_phase == PH_BODY && pos >= body_end) begin
            env_phase = PH_FADE_OUT;
            pos       = '0;
        end
        if (env_phase == PH_FADE_OUT && pos >= fade_out_len) begin
            env_phase = PH_DONE;
            return;
        end

        if (env_phase == PH_FADE_IN) begin
            r    = ratio_q16(pos, fade_in_len);
            cube = (r * r * r) >> 32;
            gain = cube[16:0];
        end else if (env_phase == PH_BODY) begin
            gain = 17'h10000;
        end else begin
            r    = 64'd65536 - ratio_q16(pos, fade_out_len);
            gain = r[16:0];
            flag = (({1'b0, pos} + 25'd1) == {1'b0, fade_out_len});
        end

        item.smp     = scale_sample(smp, gain, volume);
        item.is_last = flag;
        faded_q.push_back(item);

        if (pos != '1) begin
            pos = pos + 1'b1;
        end
        if (flag) begin
            env_phase = PH_DONE;
        end
    endtask

    always @(posedge i_clk) begin
        t_faded_sample exp_item;
        if (!i_rst_n) begin
            lead_len     = '0;
            skip_len     = SKIP_RESET;
            fade_in_len  = '0;
            body_end     = '0;
            fade_out_len = '0;
            volume       = VOLUME_RESET;
            env_phase    = PH_LEAD;
            lead_cnt     = '0;
            skip_cnt     = '0;
            pos          = '0;
            faded_q.delete();
        end else begin
            // Register writes.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LEAD_DISCARD: lead_len     = i_cfg_data[23:0];
                    REG_SKIP_COUNT:   skip_len     = i_cfg_data[15:0];
                    REG_FADE_IN_LEN:  fade_in_len  = i_cfg_data[23:0];
                    REG_BODY_END:     body_end     = i_cfg_data[23:0];
                    REG_FADE_OUT_LEN: fade_out_len = i_cfg_data[23:0];
                    REG_VOLUME_GAIN:  volume       = i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // Accepted input item.
            if (s_axis_tvalid && s_axis_tready) begin
                envelope_step(s_axis_tdata);
            end

            // Accepted output item against the oldest expectation.
            if (m_axis_tvalid && m_axis_tready) begin
                if (faded_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: unexpected output item, got sample %0d last %0b",
                             $time, $signed(m_axis_tdata), m_axis_tlast);
                end else begin
                    exp_item = faded_q.pop_front();
                    if (m_axis_tdata !== exp_item.smp) begin
                        mismatches = mismatches + 1;
                        $display("%0t: out_sample mismatch, expected %0d got %0d",
                                 $time, $signed(exp_item.smp), $signed(m_axis_tdata));
                    end
                    if (m_axis_tlast !== exp_item.is_last) begin
                        mismatches = mismatches + 1;
                        $display("%0t: final_flag mismatch, expected %0b got %0b",
                                 $time, exp_item.is_last, m_axis_tlast);
                    end
                end
            end
        end
        o_pending <= faded_q.size();
    end

endmodule

[sim/tb_audio_fade_decimator_top.sv]
`timescale 1ns / 100ps

module tb_audio_fade_decimator_top;
    import afd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;  // in_sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;       // out_sample
    logic                  m_axis_tlast;

    int error_count;
    int pending;
    int stall_cycles = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int burst_left = 0;

    logic [15:0]           sample_q[$];
    logic [CFG_IDX_W-1:0]  reg_idx_q[$];
    logic [CFG_DATA_W-1:0] reg_val_q[$];

    always #2 i_clk = ~i_clk;

    audio_fade_decimator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    afd_envelope_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    // Watchdog: ends the run when no channel has moved an item for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Output side: random ready patterns, plus a long hold-off on request.
    initial begin
        int unsigned mode;
        int unsigned span;
        @(posedge i_clk);
        forever begin
            if (holds_done != holds_asked) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done = holds_done + 1;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 64);
                repeat (span) begin
                    if (holds_done != holds_asked) break;
                    case (mode)
                        0: m_axis_tready <= 1'b1;
                        1: m_axis_tready <= 1'($urandom_range(0, 1));
                        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Mostly random samples, with full-scale and near-zero values mixed in.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 15));
            3: return 16'hFFFF - 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_volume();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd65535;
            2, 3: return 32'd4096;
            default: return 32'($urandom_range(1, 65534));
        endcase
    endfunction

    task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        reg_idx_q.push_back(idx);
        reg_val_q.push_back(val);
    endtask

    // Writes every queued register back to back.
    task automatic write_regs();
        while (reg_idx_q.size() > 0) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_idx_q.pop_front();
            i_cfg_data  <= reg_val_q.pop_front();
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Offers every queued sample in bursts separated by random gaps.
    task automatic send_samples();
        int unsigned gap;
        while (sample_q.size() > 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= sample_q.pop_front();
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            burst_left = burst_left - 1;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Waits for every expected item, then lets trailing dropped items drain.
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned fade_len;
        int unsigned skip;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Lead-in at its largest: everything is dropped.
        queue_reg(REG_LEAD_DISCARD, 32'hFF_FFFF);
        queue_reg(REG_SKIP_COUNT, 32'd0);
        queue_reg(REG_FADE_IN_LEN, 32'hFF_FFFF);
        queue_reg(REG_BODY_END, 32'hFF_FFFF);
        queue_reg(REG_FADE_OUT_LEN, 32'hFF_FFFF);
        queue_reg(REG_VOLUME_GAIN, 32'd65535);
        write_regs();
        sample_q = '{16'h7FFF, 16'h8000, 16'h0001};
        send_samples();
        wait_idle();

        // Shorter lead-in already passed; the longest fade-in gives zero gain.
        queue_reg(REG_LEAD_DISCARD, 32'd2);
        write_regs();
        sample_q = '{16'h7FFF, 16'h8000};
        send_samples();
        wait_idle();

        // Short cubic fade-in at unity volume.
        queue_reg(REG_FADE_IN_LEN, 32'd12);
        queue_reg(REG_VOLUME_GAIN, 32'd4096);
        write_regs();
        sample_q = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h0000,
                     16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 16'h1234};
        send_samples();
        wait_idle();

        // Body at full volume: saturation and truncation toward zero.
        queue_reg(REG_VOLUME_GAIN, 32'd65535);
        write_regs();
        sample_q = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 16'h0008, 16'hFFF7};
        send_samples();
        wait_idle();

        // Zero volume.
        queue_reg(REG_VOLUME_GAIN, 32'd0);
        write_regs();
        sample_q = '{16'h7FFF, 16'h8000};
        send_samples();
        wait_idle();

        // Largest skip: these items are all dropped.
        queue_reg(REG_SKIP_COUNT, 32'd65535);
        write_regs();
        repeat (4) sample_q.push_back(pick_sample());
        send_samples();
        wait_idle();

        // Random body segments with varying decimation and volume.
        for (int seg = 0; seg < 8; seg++) begin
            queue_reg(REG_SKIP_COUNT, 32'($urandom_range(0, 3)));
            queue_reg(REG_VOLUME_GAIN, pick_volume());
            if (seg == 2) begin
                queue_reg(REG_LEAD_DISCARD, 32'd0);
                queue_reg(REG_FADE_IN_LEN, 32'd0);
            end
            if (seg == 5) begin
                queue_reg(REG_BODY_END, 32'($urandom_range(100000, 24'hFF_FFFE)));
            end
            write_regs();
            repeat (60) sample_q.push_back(pick_sample());
            // One segment runs into a long output hold-off to back up the input.
            if (seg == 3) begin
                holds_asked = holds_asked + 1;
            end
            send_samples();
            wait_idle();
        end

        // End the body; fade-out first with its longest length.
        queue_reg(REG_BODY_END, 32'd0);
        queue_reg(REG_FADE_OUT_LEN, 32'hFF_FFFF);
        queue_reg(REG_SKIP_COUNT, 32'd0);
        queue_reg(REG_VOLUME_GAIN, 32'd4096);
        write_regs();
        repeat (20) sample_q.push_back(pick_sample());
        send_samples();
        wait_idle();

        // Shorten the fade-out so it runs to its flagged last sample.
        fade_len = $urandom_range(60, 120);
        skip     = $urandom_range(0, 1);
        queue_reg(REG_FADE_OUT_LEN, 32'(fade_len));
        queue_reg(REG_SKIP_COUNT, 32'(skip));
        queue_reg(REG_VOLUME_GAIN, 32'($urandom_range(2048, 8192)));
        write_regs();
        repeat (fade_len * (skip + 1) + 10) sample_q.push_back(pick_sample());
        send_samples();
        wait_idle();

        // After the last sample nothing more comes out.
        queue_reg(REG_FADE_OUT_LEN, 32'd0);
        write_regs();
        repeat (5) sample_q.push_back(pick_sample());
        send_samples();
        wait_idle();

        if (error_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[audio_fade_decimator_top.f]
rtl/core/afd_pkg.sv
rtl/core/afd_ctrl.sv
rtl/core/afd_dp.sv
rtl/core/audio_fade_decimator_top.sv
rtl/core/afd_chk.sv
sim/afd_envelope_checker.sv
sim/tb_audio_fade_decimator_top.sv
